>>> design/mee_pkg.sv
// Shared types and constants for the escape-time unit.
package mee_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_PREP,
    ST_DIV,
    ST_QUO,
    ST_MAP,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } mee_state_e;

endpackage

>>> design/mandelbrot_escape_time.sv
// Mandelbrot escape-time unit: pixel mapping, iteration loop and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------------
//  in      | in        | in_valid_i / in_stall_o  | pixel_col_i, pixel_row_i
//  out     | out       | out_valid_o / out_stall_i| out_col_o, out_row_o, iteration_count_o,
//          |           |                        | inside_set_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One pixel at a time. Per axis, mapping takes a product, a sign fix-up, three 16-bit
// quotient digits by reciprocal multiplication (multiply, then digit and remainder) and a
// saturating add.
// Each iteration then has a registered complex square, then the update and escape test;
// the loop is left at the limit from the square state or on escape from the update state,
// and then the result register is loaded.
// Reset restores the view registers and the limit, and empties the result register.
// A finished result waits in the result register; a new pixel is taken meanwhile and only
// holds at its end while that register is still stalled.
module mandelbrot_escape_time #(
  parameter int unsigned SCREEN_WIDTH  = 1024,
  parameter int unsigned SCREEN_HEIGHT = 768,
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [mee_pkg::COORD_W-1:0]            pixel_col_i,
  input  logic [mee_pkg::COORD_W-1:0]            pixel_row_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [mee_pkg::COORD_W-1:0]            out_col_o,
  output logic [mee_pkg::COORD_W-1:0]            out_row_o,
  output logic [mee_pkg::CNT_W-1:0]              iteration_count_o,
  output logic                                   inside_set_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mee_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [mee_pkg::WORD_W-1:0]             cfg_data_i
);
  import mee_pkg::*;

  localparam int unsigned DIFF_W  = WORD_W + 1;
  localparam int unsigned PROD_W  = COORD_W + 1 + DIFF_W;
  localparam int unsigned NUM_W   = PROD_W - 1;
  localparam int unsigned SUM_W   = NUM_W + 2;
  localparam int unsigned DV_MAX  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int unsigned DV_W    = $clog2(DV_MAX + 1);
  localparam int unsigned DIG_W   = 16;
  localparam int unsigned N_DIG   = (NUM_W + DIG_W - 1) / DIG_W;
  localparam int unsigned DVD_W   = N_DIG * DIG_W;
  localparam int unsigned X_W     = DV_W + DIG_W;
  localparam int unsigned RCP_W   = X_W + 1;
  localparam int unsigned P_W     = X_W + RCP_W;
  localparam int unsigned SH_X    = X_W + $clog2(SCREEN_WIDTH);
  localparam int unsigned SH_Y    = X_W + $clog2(SCREEN_HEIGHT);
  localparam logic [RCP_W-1:0] RCP_X =
    RCP_W'(((64'd1 << SH_X) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));
  localparam logic [RCP_W-1:0] RCP_Y =
    RCP_W'(((64'd1 << SH_Y) + 64'(SCREEN_HEIGHT) - 64'd1) / 64'(SCREEN_HEIGHT));
  localparam int unsigned STEP_W  = $clog2(N_DIG + 1);
  localparam int unsigned SQ_W    = 2 * WORD_W;
  localparam bit          REACH   = (2 * FRACTION_BITS + 2) <= 62;
  localparam logic [SQ_W-1:0] BOUND = REACH ? (SQ_W'(1) << (2 * FRACTION_BITS + 2)) : '0;

  function automatic logic [WORD_W-1:0] sat_word(input logic signed [SQ_W-1:0] v);
    logic signed [SQ_W-1:0] hi;
    logic signed [SQ_W-1:0] lo;
    hi = SQ_W'({1'b0, {(WORD_W-1){1'b1}}});
    lo = -hi - SQ_W'(1);
    if (v > hi) begin
      sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_word = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat_word = v[WORD_W-1:0];
    end
  endfunction

  // configuration
  logic signed [WORD_W-1:0] left_q, right_q, top_q, bottom_q;
  logic        [CNT_W-1:0]  limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= -32'sd536870912;
      right_q  <= 32'sd268435456;
      top_q    <= 32'sd301989888;
      bottom_q <= -32'sd301989888;
      limit_q  <= 16'd1024;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VIEW_LEFT:   left_q   <= cfg_data_i;
        REG_VIEW_RIGHT:  right_q  <= cfg_data_i;
        REG_VIEW_TOP:    top_q    <= cfg_data_i;
        REG_VIEW_BOTTOM: bottom_q <= cfg_data_i;
        REG_ITER_LIMIT:  limit_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  mee_state_e          state_q, state_d;
  logic                axis_q, axis_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;

  // payload
  logic [COORD_W-1:0]       col_q, col_d, row_q, row_d;
  logic signed [PROD_W-1:0] n_q, n_d;
  logic                     neg_q, neg_d;
  logic [DVD_W-1:0]         quo_q, quo_d;
  logic [DV_W-1:0]          rem_q, rem_d;
  logic [P_W-1:0]           pq_q, pq_d;
  logic signed [WORD_W-1:0] cre_q, cre_d, cim_q, cim_d;
  logic signed [WORD_W-1:0] zr_q, zr_d, zi_q, zi_d;
  logic signed [SQ_W-1:0]   rr_q, rr_d, ii_q, ii_d, ri_q, ri_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [COORD_W-1:0]       ocol_q, ocol_d, orow_q, orow_d;
  logic [CNT_W-1:0]         ocnt_q, ocnt_d;
  logic                     oins_q, oins_d;

  // datapath
  logic signed [DIFF_W-1:0] diff;
  logic [COORD_W-1:0]       pix;
  logic signed [PROD_W-1:0] n_abs;
  logic [NUM_W-1:0]         dvd;
  logic [DV_W-1:0]          dv;
  logic [DIG_W-1:0]         digit;
  logic [X_W-1:0]           part;
  logic [RCP_W-1:0]         rcp;
  logic [DIG_W-1:0]         q_dig;
  logic [X_W-1:0]           part_rem;
  logic signed [SUM_W-1:0]  q_s, lo_s, c_sum;
  logic [WORD_W-1:0]        c_sat;
  logic [SQ_W-1:0]          mag2;
  logic signed [SQ_W-1:0]   nr, ni;
  logic                     escape;

  always_comb begin
    diff = axis_q ? (DIFF_W'(bottom_q) - DIFF_W'(top_q)) : (DIFF_W'(right_q) - DIFF_W'(left_q));
    pix  = axis_q ? row_q : col_q;
    dv   = axis_q ? DV_W'(SCREEN_HEIGHT) : DV_W'(SCREEN_WIDTH);

    // floor of a negative quotient: divide |n| + dv - 1 and negate
    n_abs = n_q[PROD_W-1] ? -n_q : n_q;
    dvd   = n_abs[NUM_W-1:0] + (n_q[PROD_W-1] ? (NUM_W'(dv) - NUM_W'(1)) : '0);

    // one quotient digit per pass: remainder and next digit over the constant divisor
    digit    = quo_q[DVD_W-1 -: DIG_W];
    part     = {rem_q, digit};
    rcp      = axis_q ? RCP_Y : RCP_X;
    q_dig    = axis_q ? DIG_W'(pq_q >> SH_Y) : DIG_W'(pq_q >> SH_X);
    part_rem = part - X_W'(q_dig) * X_W'(dv);

    q_s   = neg_q ? -$signed({2'b00, quo_q[NUM_W-1:0]}) : $signed({2'b00, quo_q[NUM_W-1:0]});
    lo_s  = axis_q ? SUM_W'(top_q) : SUM_W'(left_q);
    c_sum = lo_s + q_s;
    c_sat = sat_word(SQ_W'(c_sum));

    mag2   = rr_q + ii_q;
    escape = REACH && (mag2 >= BOUND);
    nr     = ((rr_q - ii_q) >>> FRACTION_BITS) + SQ_W'(cre_q);
    ni     = (ri_q >>> (FRACTION_BITS - 1)) + SQ_W'(cim_q);
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    col_d  = col_q;
    row_d  = row_q;
    n_d    = n_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    pq_d   = pq_q;
    cre_d  = cre_q;
    cim_d  = cim_q;
    zr_d   = zr_q;
    zi_d   = zi_q;
    rr_d   = rr_q;
    ii_d   = ii_q;
    ri_d   = ri_q;
    cnt_d  = cnt_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    ocnt_d = ocnt_q;
    oins_d = oins_q;
    in_stall_o = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          col_d   = pixel_col_i;
          row_d   = pixel_row_i;
          axis_d  = 1'b0;
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        n_d     = $signed({1'b0, pix}) * diff;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        neg_d   = n_q[PROD_W-1];
        state_d = ST_DIV;
        step_d  = '0;
        rem_d   = '0;
        quo_d   = DVD_W'(dvd);
      end
      ST_DIV: begin
        pq_d    = part * rcp;
        state_d = ST_QUO;
      end
      ST_QUO: begin
        rem_d  = part_rem[DV_W-1:0];
        quo_d  = {quo_q[DVD_W-DIG_W-1:0], q_dig};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(N_DIG - 1)) begin
          state_d = ST_MAP;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_MAP: begin
        if (axis_q) begin
          cim_d   = c_sat;
          zr_d    = '0;
          zi_d    = '0;
          cnt_d   = '0;
          state_d = ST_MUL;
        end else begin
          cre_d   = c_sat;
          axis_d  = 1'b1;
          state_d = ST_PROD;
        end
      end
      ST_MUL: begin
        if (cnt_q < limit_q) begin
          rr_d    = zr_q * zr_q;
          ii_d    = zi_q * zi_q;
          ri_d    = zr_q * zi_q;
          state_d = ST_UPD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_UPD: begin
        if (escape) begin
          state_d = ST_DONE;
        end else begin
          zr_d    = sat_word(nr);
          zi_d    = sat_word(ni);
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ocol_d      = col_q;
          orow_d      = row_q;
          ocnt_d      = cnt_q;
          oins_d      = (cnt_q == limit_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    n_q    <= n_d;
    neg_q  <= neg_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    pq_q   <= pq_d;
    cre_q  <= cre_d;
    cim_q  <= cim_d;
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    rr_q   <= rr_d;
    ii_q   <= ii_d;
    ri_q   <= ri_d;
    cnt_q  <= cnt_d;
    ocol_q <= ocol_d;
    orow_q <= orow_d;
    ocnt_q <= ocnt_d;
    oins_q <= oins_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_col_o         = ocol_q;
  assign out_row_o         = orow_q;
  assign iteration_count_o = ocnt_q;
  assign inside_set_o      = oins_q;

endmodule
